FILE: hw/rtl/mfs_pkg.sv
// mfs_pkg: shared types, codes and the sigmoid table for the perceptron core
// no dependencies; imported by mfs_cell, mfs_mac and mlp_forward_sigmoid_core
package mfs_pkg;

    // network shape
    localparam int HIDDEN   = 8;
    localparam int N_SLOTS  = 4;
    localparam int NEUR_W   = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;

    // field widths
    localparam int DATA_W   = 16;
    localparam int IDX_W    = 5;
    localparam int MUL_A_W  = DATA_W + 1;
    localparam int PROD_W   = MUL_A_W + DATA_W;
    localparam int ACC1_W   = PROD_W + 1;
    localparam int ACC2_W   = PROD_W + $clog2(HIDDEN) + 1;

    // pre-activation scaling into table steps of 1/16
    localparam int SHIFT1   = 12;
    localparam int SHIFT2   = 20;

    // item codes
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_PREDICT = 1'b1;

    // weight slot inside one cell
    localparam logic [1:0] SLOT_A   = 2'd0;
    localparam logic [1:0] SLOT_B   = 2'd1;
    localparam logic [1:0] SLOT_C   = 2'd2;
    localparam logic [1:0] SLOT_OUT = 2'd3;

    // multiplier operand select
    localparam logic [1:0] MUL_A = 2'd0;
    localparam logic [1:0] MUL_B = 2'd1;
    localparam logic [1:0] MUL_C = 2'd2;
    localparam logic [1:0] MUL_H = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] wa;
        logic signed [DATA_W-1:0] wb;
        logic signed [DATA_W-1:0] wc;
        logic signed [DATA_W-1:0] wo;
    } t_weights;

    typedef struct packed {
        logic                     en;
        logic [1:0]               slot;
        logic signed [DATA_W-1:0] data;
    } t_cell_wr;

    typedef struct packed {
        logic       capture;
        logic [1:0] mul_sel;
        logic       acc1_load;
        logic       acc1_add;
        logic       h_load;
        logic       acc2_add;
        logic       out_load;
    } t_mac_ctrl;

    // sigmoid table
    localparam int SIG_ENTRIES = 256;
    localparam int SIG_BITS    = SIG_ENTRIES * DATA_W;
    localparam int EXP_STEPS   = 128;
    localparam logic [63:0] EXP_STEP = 64'd4034748382;

    // elaboration-time build: repeated rounded products for exp, long division by shifts
    function automatic logic [SIG_BITS-1:0] f_build_sig();
        logic [63:0]         e [EXP_STEPS+1];
        logic [63:0]         d;
        logic [63:0]         num;
        logic [63:0]         rem;
        logic [63:0]         q;
        logic [SIG_BITS-1:0] tab;
        int                  k;
        e[0] = 64'd1 << 32;
        for (int i = 1; i <= EXP_STEPS; i++) begin
            e[i] = (e[i-1] * EXP_STEP + (64'd1 << 31)) >> 32;
        end
        tab = '0;
        for (int n = 0; n < SIG_ENTRIES; n++) begin
            k   = (n >= EXP_STEPS) ? n - EXP_STEPS : EXP_STEPS - n;
            d   = (64'd1 << 32) + e[k];
            num = (n >= EXP_STEPS) ? (64'd1 << 48) : (e[k] << 16);
            num = num + (d >> 1);
            rem = '0;
            q   = '0;
            for (int b = 63; b >= 0; b--) begin
                rem = {rem[62:0], num[b]};
                if (rem >= d) begin
                    rem  = rem - d;
                    q[b] = 1'b1;
                end
            end
            tab[n*DATA_W +: DATA_W] = q[DATA_W-1:0];
        end
        return tab;
    endfunction

    localparam logic [SIG_BITS-1:0] SIG_TABLE = f_build_sig();

    function automatic logic [DATA_W-1:0] f_sig(input logic [7:0] idx);
        return SIG_TABLE[{idx, 4'd0} +: DATA_W];
    endfunction

    // clamp an already shifted pre-activation to [-128,127] and offset by 128
    function automatic logic [7:0] f_sig_index(input logic signed [ACC2_W-1:0] q);
        logic [7:0] idx;
        if (q[ACC2_W-1] && !(&q[ACC2_W-1:7])) begin
            idx = 8'd0;
        end else if (!q[ACC2_W-1] && (|q[ACC2_W-2:7])) begin
            idx = 8'd255;
        end else begin
            idx = {~q[7], q[6:0]};
        end
        return idx;
    endfunction

endpackage

FILE: hw/rtl/mfs_cell.sv
// mfs_cell: one link of the weight ring, holding the four weights of one hidden neuron
// depends on mfs_pkg
module mfs_cell
    import mfs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_shift,
    input  t_weights i_prev,
    input  t_cell_wr i_wr,
    output t_weights o_weights
);

    t_weights r_w;
    t_weights n_w;

    always_comb begin
        n_w = r_w;
        if (i_wr.en) begin
            case (i_wr.slot)
                SLOT_A:   n_w.wa = i_wr.data;
                SLOT_B:   n_w.wb = i_wr.data;
                SLOT_C:   n_w.wc = i_wr.data;
                SLOT_OUT: n_w.wo = i_wr.data;
                default:  n_w = r_w;
            endcase
        end else if (i_shift) begin
            n_w = i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= '0;
        end else begin
            r_w <= n_w;
        end
    end

    assign o_weights = r_w;

endmodule

FILE: hw/rtl/mfs_mac.sv
// mfs_mac: shared multiplier, both accumulators and the sigmoid lookups
// depends on mfs_pkg
module mfs_mac
    import mfs_pkg::*;
(
    input  logic                     i_clk,
    input  t_mac_ctrl                i_ctrl,
    input  logic signed [DATA_W-1:0] i_feature_a,
    input  logic signed [DATA_W-1:0] i_feature_b,
    input  logic signed [DATA_W-1:0] i_feature_c,
    input  t_weights                 i_head,
    output logic [DATA_W-1:0]        o_probability
);

    logic signed [DATA_W-1:0]  r_fa;
    logic signed [DATA_W-1:0]  r_fb;
    logic signed [DATA_W-1:0]  r_fc;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC1_W-1:0]  r_acc1;
    logic signed [ACC2_W-1:0]  r_acc2;
    logic [DATA_W-1:0]         r_h;
    logic [DATA_W-1:0]         r_prob;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [DATA_W-1:0]  mul_b;
    logic signed [ACC1_W-1:0]  q1;
    logic signed [ACC2_W-1:0]  q2;

    always_comb begin
        case (i_ctrl.mul_sel)
            MUL_A: begin
                mul_a = MUL_A_W'(r_fa);
                mul_b = i_head.wa;
            end
            MUL_B: begin
                mul_a = MUL_A_W'(r_fb);
                mul_b = i_head.wb;
            end
            MUL_C: begin
                mul_a = MUL_A_W'(r_fc);
                mul_b = i_head.wc;
            end
            MUL_H: begin
                mul_a = {1'b0, r_h};
                mul_b = i_head.wo;
            end
            default: begin
                mul_a = MUL_A_W'(r_fa);
                mul_b = i_head.wa;
            end
        endcase
    end

    // arithmetic shift gives the floor division into 1/16 steps
    assign q1 = r_acc1 >>> SHIFT1;
    assign q2 = r_acc2 >>> SHIFT2;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_ctrl.capture) begin
            r_fa   <= i_feature_a;
            r_fb   <= i_feature_b;
            r_fc   <= i_feature_c;
            r_acc2 <= '0;
        end else if (i_ctrl.acc2_add) begin
            r_acc2 <= r_acc2 + ACC2_W'(r_prod);
        end
        if (i_ctrl.acc1_load) begin
            r_acc1 <= ACC1_W'(r_prod);
        end else if (i_ctrl.acc1_add) begin
            r_acc1 <= r_acc1 + ACC1_W'(r_prod);
        end
        if (i_ctrl.h_load) begin
            r_h <= f_sig(f_sig_index(ACC2_W'(q1)));
        end
        if (i_ctrl.out_load) begin
            r_prob <= f_sig(f_sig_index(q2));
        end
    end

    assign o_probability = r_prob;

endmodule

FILE: hw/rtl/mlp_forward_sigmoid_core.sv
// mlp_forward_sigmoid_core: 3-input, HIDDEN-neuron, 1-output perceptron with sigmoid layers
// predict: after the RUN steps, DRAIN and FINISH, o_strobe rises with the result;
// the next item is taken in the cycle the result shows, and no predict is taken while busy;
// the pace is set by the single shared multiplier, six steps per hidden neuron
// load: written at the accepting edge, busy stays low; the result cannot be stalled
// reset (synchronous, active low) clears every weight to zero and returns to idle
module mlp_forward_sigmoid_core
    import mfs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_action,
    input  logic [IDX_W-1:0]         i_weight_index,
    input  logic signed [DATA_W-1:0] i_weight_value,
    input  logic signed [DATA_W-1:0] i_feature_a,
    input  logic signed [DATA_W-1:0] i_feature_b,
    input  logic signed [DATA_W-1:0] i_feature_c,
    output logic [DATA_W-1:0]        o_probability,
    output logic                     o_strobe
);

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // steps for one hidden neuron
    localparam logic [2:0] PH0 = 3'd0;
    localparam logic [2:0] PH1 = 3'd1;
    localparam logic [2:0] PH2 = 3'd2;
    localparam logic [2:0] PH3 = 3'd3;
    localparam logic [2:0] PH4 = 3'd4;
    localparam logic [2:0] PH5 = 3'd5;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [2:0]        r_phase;
    logic [2:0]        n_phase;
    logic [NEUR_W-1:0] r_neuron;
    logic [NEUR_W-1:0] n_neuron;
    logic              r_strobe;
    logic              n_strobe;

    t_mac_ctrl ctrl;
    logic      ring_shift;
    logic      load_accept;

    t_weights  w_cell  [HIDDEN];
    t_cell_wr  wr_cell [HIDDEN];

    assign busy        = (r_state != ST_IDLE);
    assign load_accept = start && !busy && (i_action == ACT_LOAD);

    // weight ring: cell 0 is the head seen by the multiplier; each rotation moves
    // every neuron's weights one cell towards the head, HIDDEN rotations bring
    // the ring back home at the end of a predict
    for (genvar j = 0; j < HIDDEN; j++) begin : g_cell
        localparam int NEXT = (j + 1) % HIDDEN;

        // store entry s*HIDDEN+j lives in cell j, slot s; entries past the store miss
        always_comb begin
            wr_cell[j].en   = 1'b0;
            wr_cell[j].slot = SLOT_A;
            wr_cell[j].data = i_weight_value;
            for (int s = 0; s < N_SLOTS; s++) begin
                if (load_accept && (int'(i_weight_index) == s * HIDDEN + j)) begin
                    wr_cell[j].en   = 1'b1;
                    wr_cell[j].slot = 2'(s);
                end
            end
        end

        mfs_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (ring_shift),
            .i_prev    (w_cell[NEXT]),
            .i_wr      (wr_cell[j]),
            .o_weights (w_cell[j])
        );
    end

    // per neuron: three feature products into acc1, table lookup, then the
    // hidden value times its output weight; that product is folded into acc2
    // during the first step of the next neuron (or the drain step after the last)
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_neuron   = r_neuron;
        n_strobe   = 1'b0;
        ring_shift = 1'b0;
        ctrl       = '0;
        ctrl.mul_sel = MUL_A;
        case (r_state)
            ST_IDLE: begin
                if (start && (i_action == ACT_PREDICT)) begin
                    ctrl.capture = 1'b1;
                    n_state      = ST_RUN;
                    n_phase      = PH0;
                    n_neuron     = '0;
                end
            end
            ST_RUN: begin
                case (r_phase)
                    PH0: begin
                        ctrl.mul_sel  = MUL_A;
                        ctrl.acc2_add = (r_neuron != '0);
                        n_phase       = PH1;
                    end
                    PH1: begin
                        ctrl.mul_sel   = MUL_B;
                        ctrl.acc1_load = 1'b1;
                        n_phase        = PH2;
                    end
                    PH2: begin
                        ctrl.mul_sel  = MUL_C;
                        ctrl.acc1_add = 1'b1;
                        n_phase       = PH3;
                    end
                    PH3: begin
                        ctrl.acc1_add = 1'b1;
                        n_phase       = PH4;
                    end
                    PH4: begin
                        ctrl.h_load = 1'b1;
                        n_phase     = PH5;
                    end
                    PH5: begin
                        ctrl.mul_sel = MUL_H;
                        ring_shift   = 1'b1;
                        n_phase      = PH0;
                        if (r_neuron == NEUR_W'(HIDDEN - 1)) begin
                            n_neuron = '0;
                            n_state  = ST_DRAIN;
                        end else begin
                            n_neuron = r_neuron + 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH0;
                    end
                endcase
            end
            ST_DRAIN: begin
                ctrl.acc2_add = 1'b1;
                n_state       = ST_FINISH;
            end
            ST_FINISH: begin
                ctrl.out_load = 1'b1;
                n_strobe      = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH0;
            r_neuron <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_neuron <= n_neuron;
            r_strobe <= n_strobe;
        end
    end

    mfs_mac u_mac (
        .i_clk         (i_clk),
        .i_ctrl        (ctrl),
        .i_feature_a   (i_feature_a),
        .i_feature_b   (i_feature_b),
        .i_feature_c   (i_feature_c),
        .i_head        (w_cell[0]),
        .o_probability (o_probability)
    );

    assign o_strobe = r_strobe;

`ifndef ASSERT_OFF
    // a result only ever follows the final lookup step
    a_strobe_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == ST_FINISH))
        else $error("result strobe without final lookup");

    // while idle the step counters sit at home, so the ring is back in place
    a_idle_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> ((r_phase == PH0) && (r_neuron == '0)))
        else $error("sequencer idle with counters away from home");

    // a load item never occupies the core
    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action == ACT_LOAD)) |=> !busy)
        else $error("load item raised busy");
`endif

endmodule

FILE: dv/mlp_forward_sigmoid_core_tb.sv
`timescale 1ns / 1ps
// mlp_forward_sigmoid_core_tb: self-checking bench for the perceptron core, weight loads and
// predictions checked against a behavioural forward pass; depends on mfs_pkg and the core
module mlp_forward_sigmoid_core_tb;
    import mfs_pkg::*;

    // cycles without any accepted item or result before the run is declared hung
    localparam int STALL_LIMIT   = 2000;
    // drain for longer than one prediction takes
    localparam int DRAIN_CYCLES  = 6 * HIDDEN + 14;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int N_WEIGHTS     = 4 * HIDDEN;
    // first layer sums are Q16.16, second layer Q8.24, table steps are 1/16
    localparam int HID_SHIFT     = 12;
    localparam int OUT_SHIFT     = 20;
    localparam logic [DATA_W-1:0] SIG_ZERO = 16'h8000;   // sigmoid(0) in Q0.16
    localparam int N_DIRECTED    = 25;

    typedef struct packed {
        logic              action;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] wv;
        logic [DATA_W-1:0] fa;
        logic [DATA_W-1:0] fb;
        logic [DATA_W-1:0] fc;
        logic              typed;   // want holds a hand-worked probability
        logic [DATA_W-1:0] want;
    } t_stim_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic                     i_action;
    logic [IDX_W-1:0]         i_weight_index;
    logic signed [DATA_W-1:0] i_feature_a;
    logic signed [DATA_W-1:0] i_feature_b;
    logic signed [DATA_W-1:0] i_feature_c;
    logic signed [DATA_W-1:0] i_weight_value;
    logic [DATA_W-1:0]        o_probability;
    logic                     o_strobe;

    // bench copy of the network and the sigmoid lookup
    logic signed [DATA_W-1:0] net_weights [N_WEIGHTS];
    logic [DATA_W-1:0]        sigmoid_lut [256];
    logic [DATA_W-1:0]        pending_probs [$];

    // hand-worked expectation that travels with the item on the pins
    logic                     cur_typed;
    logic [DATA_W-1:0]        cur_want;

    int  mismatches;
    int  loads_taken;
    int  predicts_taken;
    int  probs_checked;
    int  stall_cycles;
    int  items_sent;
    bit  calm_stretch;

    // extremes of the fields first, then loads and predictions whose sums land on both
    // saturated ends, zero, and the linear middle of the table
    t_stim_row directed_rows [N_DIRECTED] = '{
        // empty store: every sum is zero, so the output is sigmoid(0) whatever the features
        '{ACT_PREDICT, 5'd0,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, SIG_ZERO},
        '{ACT_PREDICT, 5'd0,  16'h0000, 16'h7fff, 16'h8000, 16'hffff, 1'b1, SIG_ZERO},
        // index and value are ignored on a prediction
        '{ACT_PREDICT, 5'd31, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 1'b1, SIG_ZERO},
        // load ignores the features; biggest output weight drives the top clamp
        '{ACT_LOAD,    5'd31, 16'h7fff, 16'h1234, 16'hfedc, 16'h8000, 1'b0, 16'h0000},
        '{ACT_PREDICT, 5'd0,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ACT_LOAD,    5'd0,  16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ACT_LOAD,    IDX_W'(HIDDEN),     16'h7fff, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0},
        '{ACT_LOAD,    IDX_W'(2 * HIDDEN), 16'h0001, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0},
        '{ACT_PREDICT, 5'd0,  16'h0000, 16'h7fff, 16'h8000, 16'h7fff, 1'b0, 16'h0000},
        '{ACT_LOAD,    IDX_W'(3 * HIDDEN), 16'h8000, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0},
        '{ACT_PREDICT, 5'd0,  16'h0000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 16'h0000},
        // most negative output weight drives the bottom clamp
        '{ACT_LOAD,    5'd31, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ACT_PREDICT, 5'd0,  16'h0000, 16'h0100, 16'h0100, 16'h0100, 1'b0, 16'h0000},
        '{ACT_LOAD,    5'd31, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ACT_LOAD,    IDX_W'(3 * HIDDEN), 16'h0000, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0},
        // output weights all back to zero: sigmoid(0) again despite a busy first layer
        '{ACT_PREDICT, 5'd0,  16'h0000, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1, SIG_ZERO},
        '{ACT_LOAD,    5'd1,  16'h0010, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ACT_LOAD,    IDX_W'(3 * HIDDEN + 1), 16'h0100, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0},
        // small sums either side of zero, where the floor rounding matters
        '{ACT_PREDICT, 5'd0,  16'h0000, 16'hfff0, 16'h0020, 16'hffff, 1'b0, 16'h0000},
        '{ACT_PREDICT, 5'd0,  16'h0000, 16'h0001, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ACT_LOAD,    5'd0,  16'hffff, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ACT_PREDICT, 5'd0,  16'h0000, 16'hffff, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ACT_LOAD,    IDX_W'(3 * HIDDEN + 1), 16'hff00, 16'h0, 16'h0, 16'h0, 1'b0, 16'h0},
        '{ACT_PREDICT, 5'd0,  16'h0000, 16'h0200, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ACT_PREDICT, 5'd0,  16'h0000, 16'h8000, 16'h7fff, 16'h0000, 1'b0, 16'h0000}
    };

    mlp_forward_sigmoid_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_weight_index (i_weight_index),
        .i_weight_value (i_weight_value),
        .i_feature_a    (i_feature_a),
        .i_feature_b    (i_feature_b),
        .i_feature_c    (i_feature_c),
        .o_probability  (o_probability),
        .o_strobe       (o_strobe)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // floor of the sum in table steps, clamped to the table and offset to an index
    function automatic logic [7:0] lut_index(input longint acc, input int sh);
        longint q;
        q = acc >>> sh;
        if (q < -128) begin
            q = -128;
        end else if (q > 127) begin
            q = 127;
        end
        return 8'(q + 128);
    endfunction

    // full forward pass over the bench copy of the weights, all sums exact
    function automatic logic [DATA_W-1:0] predict_probability(
        input logic signed [DATA_W-1:0] fa,
        input logic signed [DATA_W-1:0] fb,
        input logic signed [DATA_W-1:0] fc
    );
        longint            hid_sum;
        longint            out_sum;
        logic [DATA_W-1:0] hid_act;
        out_sum = 0;
        for (int j = 0; j < HIDDEN; j++) begin
            hid_sum = longint'(fa) * longint'(net_weights[j])
                    + longint'(fb) * longint'(net_weights[HIDDEN + j])
                    + longint'(fc) * longint'(net_weights[2 * HIDDEN + j]);
            hid_act = sigmoid_lut[lut_index(hid_sum, HID_SHIFT)];
            out_sum += longint'(hid_act) * longint'(net_weights[3 * HIDDEN + j]);
        end
        return sigmoid_lut[lut_index(out_sum, OUT_SHIFT)];
    endfunction

    // mostly small Q8.8 values so the sums stay inside the table, the rest anywhere
    function automatic logic [DATA_W-1:0] rand_q88();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = DATA_W'($urandom);
            3:       v = DATA_W'($urandom_range(0, 4095)) - 16'd2048;
            4:       begin
                case ($urandom_range(0, 4))
                    0: v = 16'h8000;
                    1: v = 16'h7fff;
                    2: v = 16'hffff;
                    3: v = 16'h0001;
                    default: v = 16'h0000;
                endcase
            end
            default: v = DATA_W'($urandom_range(0, 1023)) - 16'd512;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // present one item at the falling edge and hold it until the core takes it,
    // then maybe leave a gap with noise on the idle pins
    task automatic send_item(
        input logic              act,
        input logic [IDX_W-1:0]  idx,
        input logic [DATA_W-1:0] wv,
        input logic [DATA_W-1:0] fa,
        input logic [DATA_W-1:0] fb,
        input logic [DATA_W-1:0] fc,
        input logic              typed,
        input logic [DATA_W-1:0] want
    );
        int gap;
        @(negedge i_clk);
        start          = 1'b1;
        i_action       = act;
        i_weight_index = idx;
        i_weight_value = wv;
        i_feature_a    = fa;
        i_feature_b    = fb;
        i_feature_c    = fc;
        cur_typed      = typed;
        cur_want       = want;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        items_sent++;
        if (!calm_stretch && $urandom_range(0, 99) < 23) begin
            // mostly short gaps, now and then one longer than a whole prediction
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 3);
            repeat (gap) begin
                @(negedge i_clk);
                start          = 1'b0;
                i_action       = 1'($urandom);
                i_weight_index = IDX_W'($urandom);
                i_weight_value = DATA_W'($urandom);
                i_feature_a    = DATA_W'($urandom);
                i_feature_b    = DATA_W'($urandom);
                i_feature_c    = DATA_W'($urandom);
            end
        end
    endtask

    // hold the sender off until every prediction in flight has come back
    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_probs.size() != 0) @(negedge i_clk);
    endtask

    // result check first, then prediction for the item taken at this same edge
    always @(posedge i_clk) begin
        logic [DATA_W-1:0] want;
        logic              took;
        took = 1'b0;
        if (i_rst_n && o_strobe === 1'b1) begin
            took = 1'b1;
            if (pending_probs.size() == 0) begin
                report_mismatch($sformatf("probability %h with nothing outstanding",
                    o_probability));
            end else begin
                want = pending_probs.pop_front();
                probs_checked++;
                if (o_probability !== want) begin
                    report_mismatch($sformatf("probability %h, expected %h",
                        o_probability, want));
                end
            end
        end
        if (i_rst_n && start && busy === 1'b0) begin
            took = 1'b1;
            if (i_action == ACT_PREDICT) begin
                predicts_taken++;
                pending_probs.push_back(cur_typed ? cur_want
                    : predict_probability(i_feature_a, i_feature_b, i_feature_c));
            end else begin
                loads_taken++;
                // writes past the store are dropped, only possible with fewer than 8 neurons
                if (i_weight_index < N_WEIGHTS) begin
                    net_weights[i_weight_index] = i_weight_value;
                end
            end
        end
        stall_cycles = took ? 0 : stall_cycles + 1;
    end

    // hang detector, read on the falling edge so it never races the counter
    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) @(negedge i_clk);
        $display("no progress for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        logic [63:0] e_pow;
        logic [63:0] denom;
        logic [63:0] numer;
        int          k;
        int          roll;

        // sigmoid table: e^-k/16 by repeated rounded products, then a rounded quotient
        for (int n = 0; n < 256; n++) begin
            k = (n >= 128) ? n - 128 : 128 - n;
            e_pow = 64'd1 << 32;
            repeat (k) e_pow = (e_pow * 64'd4034748382 + (64'd1 << 31)) >> 32;
            denom = (64'd1 << 32) + e_pow;
            numer = (n >= 128) ? (64'd1 << 48) : (e_pow << 16);
            sigmoid_lut[n] = DATA_W'((numer + denom / 2) / denom);
        end
        for (int j = 0; j < N_WEIGHTS; j++) net_weights[j] = '0;

        mismatches     = 0;
        loads_taken    = 0;
        predicts_taken = 0;
        probs_checked  = 0;
        stall_cycles   = 0;
        items_sent     = 0;
        calm_stretch   = 1'b0;
        cur_typed      = 1'b0;
        cur_want       = '0;
        start          = 1'b0;
        i_action       = ACT_LOAD;
        i_weight_index = '0;
        i_weight_value = '0;
        i_feature_a    = '0;
        i_feature_b    = '0;
        i_feature_c    = '0;
        i_rst_n        = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].action, directed_rows[r].idx, directed_rows[r].wv,
                directed_rows[r].fa, directed_rows[r].fb, directed_rows[r].fc,
                directed_rows[r].typed, directed_rows[r].want);
        end
        wait_drained();

        // random part: single loads and predictions, with an occasional full reload
        // of the network so that whole fresh weight sets get exercised
        while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
            calm_stretch = (items_sent >= N_DIRECTED + 400) && (items_sent < N_DIRECTED + 800);
            if (items_sent == N_DIRECTED + 1000) begin
                wait_drained();
            end
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                for (int j = 0; j < N_WEIGHTS; j++) begin
                    send_item(ACT_LOAD, IDX_W'(j), rand_q88(), DATA_W'($urandom),
                        DATA_W'($urandom), DATA_W'($urandom), 1'b0, '0);
                end
            end else if (roll < 42) begin
                send_item(ACT_LOAD, IDX_W'($urandom), rand_q88(), DATA_W'($urandom),
                    DATA_W'($urandom), DATA_W'($urandom), 1'b0, '0);
            end else begin
                send_item(ACT_PREDICT, IDX_W'($urandom), DATA_W'($urandom), rand_q88(),
                    rand_q88(), rand_q88(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d weight loads and %0d predictions, %0d probabilities compared",
            loads_taken, predicts_taken, probs_checked);
        $display("sums from both clamped ends through the linear middle, sender gaps at random");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/mfs_pkg.sv
hw/rtl/mfs_cell.sv
hw/rtl/mfs_mac.sv
hw/rtl/mlp_forward_sigmoid_core.sv
dv/mlp_forward_sigmoid_core_tb.sv
